@@ hdl/oas_pkg.sv @@
// shared types, constants and command codes for the obstacle avoidance steering block
package oas_pkg;

    localparam int DIV_CYCLES_DEF = 64;

    localparam logic [30:0] BOX_MIN_RST   = 31'd655360;
    localparam logic [30:0] MAX_SPEED_RST = 31'd6553600;
    localparam logic [30:0] RADIUS_RST    = 31'd655360;

    typedef enum logic [1:0] {
        CMD_SETUP    = 2'd0,
        CMD_OBSTACLE = 2'd1,
        CMD_FINISH   = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_BOX_MIN   = 2'd0,
        CFG_MAX_SPEED = 2'd1,
        CFG_RADIUS    = 2'd2
    } cfg_idx_t;

    // datapath operation selected by the controller
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_SETUP0 = 4'd2,
        OP_SETUP1 = 4'd3,
        OP_OBS0   = 4'd4,
        OP_OBS1   = 4'd5,
        OP_OBS2   = 4'd6,
        OP_OBS3   = 4'd7,
        OP_FIN0   = 4'd8,
        OP_FIN1   = 4'd9,
        OP_FIN2   = 4'd10,
        OP_FIN3   = 4'd11,
        OP_FIN4   = 4'd12,
        OP_ITER   = 4'd13
    } op_t;

    typedef struct packed {
        op_t  op;
        logic iter_start;
    } oas_cmd_t;

    typedef struct packed {
        logic iter_done;
        logic reject;
        cmd_t cmd;
    } oas_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -80'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

@@ hdl/oas_ctrl.sv @@
// controller state machine sequencing setup, obstacle and finish beats
module oas_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  oas_pkg::oas_stat_t   stat,
    output oas_pkg::oas_cmd_t    cmd
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000000000000001,
        S_DEC   = 16'b0000000000000010,
        S_SET0  = 16'b0000000000000100,
        S_SDIV  = 16'b0000000000001000,
        S_SET1  = 16'b0000000000010000,
        S_OBS0  = 16'b0000000000100000,
        S_OBS1  = 16'b0000000001000000,
        S_OBS2  = 16'b0000000010000000,
        S_ROOT  = 16'b0000000100000000,
        S_OBS3  = 16'b0000001000000000,
        S_FIN0  = 16'b0000010000000000,
        S_FDIV  = 16'b0000100000000000,
        S_FIN1  = 16'b0001000000000000,
        S_FIN2  = 16'b0010000000000000,
        S_FIN3  = 16'b0100000000000000,
        S_OUT   = 16'b1000000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = oas_pkg::OP_NONE;
        cmd.iter_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = oas_pkg::OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (stat.cmd)
                    oas_pkg::CMD_SETUP:    state_next = S_SET0;
                    oas_pkg::CMD_OBSTACLE: state_next = S_OBS0;
                    oas_pkg::CMD_FINISH:   state_next = S_FIN0;
                    default:               state_next = S_IDLE;
                endcase
            end
            S_SET0:
            begin
                cmd.op         = oas_pkg::OP_SETUP0;
                cmd.iter_start = 1'b1;
                state_next     = S_SDIV;
            end
            S_SDIV:
            begin
                cmd.op = oas_pkg::OP_ITER;
                if (stat.iter_done)
                    state_next = S_SET1;
            end
            S_SET1:
            begin
                cmd.op     = oas_pkg::OP_SETUP1;
                state_next = S_IDLE;
            end
            S_OBS0:
            begin
                cmd.op     = oas_pkg::OP_OBS0;
                state_next = S_OBS1;
            end
            S_OBS1:
            begin
                cmd.op     = oas_pkg::OP_OBS1;
                state_next = S_OBS2;
            end
            S_OBS2:
            begin
                cmd.op = oas_pkg::OP_OBS2;
                if (stat.reject)
                    state_next = S_IDLE;
                else
                begin
                    cmd.iter_start = 1'b1;
                    state_next     = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.op = oas_pkg::OP_ITER;
                if (stat.iter_done)
                    state_next = S_OBS3;
            end
            S_OBS3:
            begin
                cmd.op     = oas_pkg::OP_OBS3;
                state_next = S_IDLE;
            end
            S_FIN0:
            begin
                cmd.op         = oas_pkg::OP_FIN0;
                cmd.iter_start = 1'b1;
                state_next     = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.op = oas_pkg::OP_ITER;
                if (stat.iter_done)
                    state_next = S_FIN1;
            end
            S_FIN1:
            begin
                cmd.op     = oas_pkg::OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.op     = oas_pkg::OP_FIN2;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                cmd.op     = oas_pkg::OP_FIN3;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.op     = oas_pkg::OP_FIN4;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DEC) else $error("beat not decoded");

endmodule

@@ hdl/oas_dp.sv @@
// datapath: agent state, local transform, shared root/divide unit and force math
module oas_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic [1:0]         command,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [15:0]        head_x,
    input  logic [15:0]        head_y,
    input  logic [30:0]        speed,
    input  logic [30:0]        radius,
    input  logic               tagged_req,
    input  oas_pkg::oas_cmd_t  cmd,
    output oas_pkg::oas_stat_t stat,
    output logic [31:0]        force_x,
    output logic [31:0]        force_y,
    output logic               found
);

    localparam int DIV_CYCLES = oas_pkg::DIV_CYCLES_DEF;
    localparam int CW = $clog2(DIV_CYCLES + 1);

    logic [30:0] box_min_reg, max_speed_reg, agent_r_reg;
    logic signed [31:0] ax_reg, ay_reg;
    logic signed [15:0] hx_reg, hy_reg;
    logic [31:0] box_len_reg;
    logic [31:0] best_d_reg;
    logic signed [31:0] best_lx_reg, best_ly_reg;
    logic [30:0] best_r_reg;
    logic have_best_reg;

    logic [1:0] cmd_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] ihx_reg, ihy_reg;
    logic [30:0] spd_reg, rad_reg;
    logic tag_reg;

    logic signed [47:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [31:0] lx_reg, ly_reg;
    logic [31:0] er_reg;

    // shared iterative unit: restoring divide or bit-pair square root
    logic [63:0] rem_reg, num_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic root_mode_reg, neg_reg;

    logic signed [31:0] m_reg, lat_reg, brk_reg;
    logic signed [31:0] fx_reg, fy_reg;
    logic found_reg;

    // combinational helpers
    logic signed [32:0] dx, dy;
    logic signed [63:0] lx_sum, ly_sum;
    logic signed [31:0] lx_c, ly_c;
    logic [31:0] aly;
    logic [63:0] rad_sq;
    logic [64:0] trial;
    logic [CW-1:0] cnt_m1;
    logic [63:0] root_bit;
    logic [64:0] root_sum;
    logic signed [33:0] ip_a, ip_b, ip_sel;
    logic [31:0] ip_sat;
    logic signed [63:0] numer_s;
    logic [63:0] numer_mag;
    logic signed [64:0] quo_s;
    logic signed [64:0] m_sum;
    logic signed [32:0] dlat_raw;
    logic signed [31:0] dlat;
    logic signed [63:0] lat_prod;
    logic signed [32:0] brk_raw;
    logic [31:0] brk_mag;
    logic [63:0] brk_prod;
    logic [31:0] brk_q;
    logic signed [63:0] fxs, fys;

    assign dx = {px_reg[31], px_reg} - {ax_reg[31], ax_reg};
    assign dy = {py_reg[31], py_reg} - {ay_reg[31], ay_reg};
    assign lx_sum = 64'(p0_reg) + 64'(p1_reg);
    assign ly_sum = 64'(p2_reg) - 64'(p3_reg);
    assign lx_c = oas_pkg::sat32(80'(lx_sum >>> 14));
    assign ly_c = oas_pkg::sat32(80'(ly_sum >>> 14));
    assign aly  = ly_reg[31] ? 32'(-33'(ly_reg)) : ly_reg;
    assign rad_sq = 64'(er_reg) * 64'(er_reg) - 64'(aly) * 64'(aly);

    assign trial    = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
    assign cnt_m1   = cnt_reg - CW'(1);
    assign root_bit = 64'd1 << {cnt_m1, 1'b0};
    assign root_sum = 65'(quo_reg) + 65'(root_bit);

    assign ip_a   = 34'(lx_reg) - 34'(quo_reg[31:0]);
    assign ip_b   = 34'(lx_reg) + 34'(quo_reg[31:0]);
    assign ip_sel = (ip_a <= 0) ? ip_b : ip_a;
    assign ip_sat = (ip_sel > 34'sh0ffffffff) ? 32'hffffffff : ip_sel[31:0];

    assign numer_s   = (64'(box_len_reg) - 64'(best_lx_reg)) <<< 16;
    assign numer_mag = numer_s[63] ? 64'(-numer_s) : numer_s;

    // signed quotient, truncated toward zero, plus one
    assign quo_s = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign m_sum = quo_s + 65'sd65536;

    assign dlat_raw = 33'(best_r_reg) - 33'(best_ly_reg);
    assign dlat     = oas_pkg::sat32(80'(dlat_raw));
    assign lat_prod = 64'(dlat) * 64'(m_reg);
    assign brk_raw  = 33'(best_r_reg) - 33'(best_lx_reg);

    // divide by five through a reciprocal multiply on the magnitude
    assign brk_mag  = brk_raw[32] ? 32'(-brk_raw) : brk_raw[31:0];
    assign brk_prod = 64'(brk_mag) * 64'h00000000cccccccd;
    assign brk_q    = 32'(brk_prod >> 34);

    assign fxs = 64'(brk_reg) * 64'(hx_reg) - 64'(lat_reg) * 64'(hy_reg);
    assign fys = 64'(brk_reg) * 64'(hy_reg) + 64'(lat_reg) * 64'(hx_reg);

    assign stat.cmd       = oas_pkg::cmd_t'(cmd_reg);
    assign stat.reject    = !tag_reg || lx_reg[31] || (aly >= er_reg);
    assign stat.iter_done = (cnt_reg == '0);

    assign force_x = fx_reg;
    assign force_y = fy_reg;
    assign found   = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg   <= oas_pkg::BOX_MIN_RST;
            max_speed_reg <= oas_pkg::MAX_SPEED_RST;
            agent_r_reg   <= oas_pkg::RADIUS_RST;
            ax_reg        <= '0;
            ay_reg        <= '0;
            hx_reg        <= 16'sd16384;
            hy_reg        <= '0;
            box_len_reg   <= 32'(oas_pkg::BOX_MIN_RST);
            best_d_reg    <= '1;
            best_lx_reg   <= '0;
            best_ly_reg   <= '0;
            best_r_reg    <= '0;
            have_best_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (oas_pkg::cfg_idx_t'(cfg_index))
                    oas_pkg::CFG_BOX_MIN:   box_min_reg   <= cfg_data;
                    oas_pkg::CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                    oas_pkg::CFG_RADIUS:    agent_r_reg   <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                oas_pkg::OP_SETUP0:
                begin
                    ax_reg <= px_reg;
                    ay_reg <= py_reg;
                    hx_reg <= ihx_reg;
                    hy_reg <= ihy_reg;
                    best_d_reg    <= '1;
                    have_best_reg <= 1'b0;
                end
                oas_pkg::OP_SETUP1:
                begin
                    if (max_speed_reg == '0 || quo_reg[63:32] != '0 ||
                        (33'(box_min_reg) + 33'(quo_reg[31:0])) > 33'h0ffffffff)
                        box_len_reg <= '1;
                    else
                        box_len_reg <= 32'(box_min_reg) + quo_reg[31:0];
                end
                oas_pkg::OP_OBS3:
                begin
                    if (!have_best_reg || ip_sat < best_d_reg)
                    begin
                        best_d_reg    <= ip_sat;
                        best_lx_reg   <= lx_reg;
                        best_ly_reg   <= ly_reg;
                        best_r_reg    <= rad_reg;
                        have_best_reg <= 1'b1;
                    end
                end
                oas_pkg::OP_FIN4:
                begin
                    best_d_reg    <= '1;
                    have_best_reg <= 1'b0;
                end
                default: ;
            endcase
            if (cmd.iter_start)
                cnt_reg <= CW'(DIV_CYCLES);
            else if (cmd.op == oas_pkg::OP_ITER && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            oas_pkg::OP_LOAD:
            begin
                cmd_reg <= command;
                px_reg  <= pos_x;
                py_reg  <= pos_y;
                ihx_reg <= head_x;
                ihy_reg <= head_y;
                spd_reg <= speed;
                rad_reg <= radius;
                tag_reg <= tagged_req;
            end
            oas_pkg::OP_SETUP0:
            begin
                root_mode_reg <= 1'b0;
                neg_reg <= 1'b0;
                rem_reg <= '0;
                quo_reg <= 64'(spd_reg) * 64'(box_min_reg);
                den_reg <= 64'(max_speed_reg);
            end
            oas_pkg::OP_OBS0:
            begin
                p0_reg <= 48'(dx) * 48'(hx_reg);
                p1_reg <= 48'(dy) * 48'(hy_reg);
                p2_reg <= 48'(dy) * 48'(hx_reg);
                p3_reg <= 48'(dx) * 48'(hy_reg);
            end
            oas_pkg::OP_OBS1:
            begin
                lx_reg <= lx_c;
                ly_reg <= ly_c;
                er_reg <= 32'(rad_reg) + 32'(agent_r_reg);
            end
            oas_pkg::OP_OBS2:
            begin
                root_mode_reg <= 1'b1;
                num_reg <= rad_sq;
                quo_reg <= '0;
            end
            oas_pkg::OP_FIN0:
            begin
                root_mode_reg <= 1'b0;
                neg_reg <= numer_s[63];
                rem_reg <= '0;
                quo_reg <= numer_mag;
                den_reg <= 64'(box_len_reg);
                brk_reg <= brk_raw[32] ? 32'(-brk_q) : brk_q;
            end
            oas_pkg::OP_FIN1:
            begin
                if (box_len_reg == '0)
                    m_reg <= 32'sd65536;
                else
                    m_reg <= oas_pkg::sat32(80'(m_sum));
            end
            oas_pkg::OP_FIN2:
            begin
                lat_reg <= oas_pkg::sat32(80'(lat_prod >>> 16));
            end
            oas_pkg::OP_FIN3:
            begin
                if (have_best_reg)
                begin
                    fx_reg <= oas_pkg::sat32(80'(fxs >>> 14));
                    fy_reg <= oas_pkg::sat32(80'(fys >>> 14));
                end
                else
                begin
                    fx_reg <= '0;
                    fy_reg <= '0;
                end
                found_reg <= have_best_reg;
            end
            oas_pkg::OP_ITER:
            begin
                if (cnt_reg != '0)
                begin
                    if (root_mode_reg)
                    begin
                        if (cnt_reg <= CW'(32))
                        begin
                            if (65'(num_reg) >= root_sum)
                            begin
                                num_reg <= num_reg - root_sum[63:0];
                                quo_reg <= (quo_reg >> 1) + root_bit;
                            end
                            else
                                quo_reg <= quo_reg >> 1;
                        end
                    end
                    else if (!trial[64])
                    begin
                        rem_reg <= trial[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[62:0], quo_reg[63]};
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.iter_start |=> cnt_reg == CW'(DIV_CYCLES)) else $error("unit not started");
    a_best_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !have_best_reg |-> best_d_reg == '1) else $error("distance not cleared");
    a_obs_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == oas_pkg::OP_OBS3 |=> have_best_reg) else $error("candidate lost");

endmodule

@@ hdl/obstacle_avoidance_steering.sv @@
// top level of the obstacle avoidance steering block
//  channel | signals                                        | dir
//  in      | in_valid/in_ready, command..tagged_req         | in
//  out     | out_valid/out_ready, force_x, force_y, found   | out
//  cfg     | cfg_we, cfg_index, cfg_data                    | in
// path from accept to ready again: setup runs the divider, obstacle runs the
// square root unless it is rejected, finish runs the divider and then holds the
// result until out_ready is high, an unknown command goes straight back to idle
// one beat is in work at a time; the result register holds until taken
// reset restores registers and agent state, clears the scan
module obstacle_avoidance_steering (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [15:0] head_x,
    input  logic [15:0] head_y,
    input  logic [30:0] speed,
    input  logic [30:0] radius,
    input  logic        tagged_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] force_x,
    output logic [31:0] force_y,
    output logic        found
);

    oas_pkg::oas_cmd_t  cmd;
    oas_pkg::oas_stat_t stat;

    oas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    oas_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .head_x     (head_x),
        .head_y     (head_y),
        .speed      (speed),
        .radius     (radius),
        .tagged_req (tagged_req),
        .cmd        (cmd),
        .stat       (stat),
        .force_x    (force_x),
        .force_y    (force_y),
        .found      (found)
    );

endmodule
